// File: hdl/palette_nearest_color_match_unit_macros.svh
// Assertion shorthands for the palette matcher, clocked on clock and held off in reset.
`ifndef PALETTE_NEAREST_COLOR_MATCH_UNIT_MACROS_SVH
`define PALETTE_NEAREST_COLOR_MATCH_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PNCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PNCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/pncm_pkg.sv
package pncm_pkg;

   localparam int unsigned PaletteEntries = 256;
   localparam int unsigned ComponentBits  = 8;

   localparam int unsigned CompWidth    = 8;
   localparam int unsigned ProdWidth    = 2 * CompWidth;
   localparam int unsigned LimitWidth   = CompWidth + 1;
   localparam int unsigned DistWidth    = ProdWidth + 2;
   localparam int unsigned Lanes        = 3;
   localparam int unsigned OpWidth      = 2;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 16;

   localparam logic [CompWidth-1:0] AlphaFull = 8'd255;

   typedef logic [CompWidth-1:0] comp_type;
   typedef comp_type [Lanes-1:0] rgb_type;     // lane 2 red, lane 1 green, lane 0 blue
   typedef logic [ProdWidth-1:0] prod_type;
   typedef prod_type [Lanes-1:0] prod3_type;

   typedef enum logic [OpWidth-1:0] {
      OP_WRITE = 2'd0,
      OP_FIND  = 2'd1,
      OP_BLEND = 2'd2
   } opcode_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_BLEND_RED   = 3'd0,
      CSR_BLEND_GREEN = 3'd1,
      CSR_BLEND_BLUE  = 3'd2,
      CSR_BLEND_ALPHA = 3'd3,
      CSR_BLEND_LIMIT = 3'd4
   } csr_type;

   // Exact x / 255 for any x up to 255 * 255.
   function automatic comp_type div255(input prod_type x);
      logic [ProdWidth:0] t;
      t = (ProdWidth+1)'(x) + (ProdWidth+1)'(x[ProdWidth-1:CompWidth]) + (ProdWidth+1)'(1);
      return t[ProdWidth-1:CompWidth];
   endfunction

   function automatic comp_type abs_diff(input comp_type a, input comp_type b);
      return (a > b) ? comp_type'(a - b) : comp_type'(b - a);
   endfunction

   function automatic logic [LimitWidth-1:0] clamp_limit(input logic [LimitWidth-1:0] lim,
                                                         input logic [LimitWidth-1:0] top);
      return (lim > top) ? top : lim;
   endfunction

endpackage

// File: hdl/pncm_ram.sv
module pncm_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: hdl/pncm_mul.sv
// Three-lane multiplier with registered products, shared by the blend and the search.
module pncm_mul (
   input  logic                clock,
   input  pncm_pkg::rgb_type   op_a,
   input  pncm_pkg::rgb_type   op_b,
   output pncm_pkg::prod3_type prod_ff
);

   pncm_pkg::prod3_type prod_in;

   always_comb begin
      for (int l = 0; l < pncm_pkg::Lanes; l++) begin
         prod_in[l] = pncm_pkg::ProdWidth'(op_a[l]) * pncm_pkg::ProdWidth'(op_b[l]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: hdl/palette_nearest_color_match_unit.sv
// Palette nearest-color matcher. Holds a palette of PALETTE_ENTRIES RGB entries (all black
// after reset) and serves one request at a time on req_, answering on rsp_. Opcode write
// stores one entry and gives no response; an out-of-range index is dropped.
// Opcode find scans entries 0 to search_limit-1 (clamped to the palette size) and returns the
// entry of least squared RGB distance, lower index on ties; a limit of zero answers index 0
// with found low. Opcode blend mixes the chosen entry with the blend color at blend alpha,
// each term divided by 255 and truncated, then searches the first blend_search_limit entries
// for the mix. The palette memory has one read port and the scan reads one entry per cycle
// through a read, square and compare pipeline; a zero limit skips the scan and the pipeline
// drain. req_tready stays low from acceptance of a find or blend until its response is
// loaded into the output register; a response that waits on rsp_tready does not block the
// next request. No clearing pass runs after reset: per-entry valid bits make unwritten
// entries read as black. Write the csr_ registers only while the block is idle.
`include "palette_nearest_color_match_unit_macros.svh"

module palette_nearest_color_match_unit #(
   parameter int unsigned PALETTE_ENTRIES = pncm_pkg::PaletteEntries,
   parameter int unsigned COMPONENT_BITS  = pncm_pkg::ComponentBits
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // index[7:0], red[15:8], green[23:16], blue[31:24], search_limit[40:32], zero[47:41]
   input  logic [pncm_pkg::ReqDataWidth-1:0]    req_tdata,
   // opcode[1:0]
   input  logic [pncm_pkg::OpWidth-1:0]         req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // match_index[7:0], found[8], zero[15:9]
   output logic [pncm_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic                                 csr_we,
   input  logic [pncm_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [pncm_pkg::LimitWidth-1:0]      csr_wdata
);

   localparam int unsigned IDX_BITS   = $clog2(PALETTE_ENTRIES);
   localparam int unsigned ENTRY_BITS = pncm_pkg::Lanes * COMPONENT_BITS;
   localparam logic [pncm_pkg::CompWidth-1:0] COMP_MASK =
      pncm_pkg::CompWidth'((16'd1 << COMPONENT_BITS) - 16'd1);
   localparam logic [pncm_pkg::LimitWidth-1:0] ENTRIES_LIM =
      pncm_pkg::LimitWidth'(PALETTE_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLEND_READ,
      ST_BLEND_MUL,
      ST_BLEND_MIX,
      ST_BLEND_SUM,
      ST_SEARCH,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // request fields
   logic [pncm_pkg::CompWidth-1:0]  req_index;
   pncm_pkg::rgb_type               req_rgb;
   logic [pncm_pkg::LimitWidth-1:0] req_limit;
   pncm_pkg::opcode_type            req_op;
   logic                            req_fire;
   logic                            req_idx_ok;

   // control and payload registers
   state_type                       state_ff, state_in;
   logic [IDX_BITS-1:0]             addr_ff, addr_in;
   logic [pncm_pkg::LimitWidth-1:0] last_ff, last_in;
   pncm_pkg::rgb_type               tgt_ff, tgt_in;
   pncm_pkg::rgb_type               quot_ff, quot_in;
   logic [IDX_BITS-1:0]             idx_ff, idx_in;
   logic                            idx_ok_ff, idx_ok_in;
   logic                            s1_vld_ff, s1_vld_in;
   logic                            s1_ok_ff, s1_ok_in;
   logic [IDX_BITS-1:0]             s1_idx_ff, s1_idx_in;
   logic                            s2_vld_ff, s2_vld_in;
   logic [IDX_BITS-1:0]             s2_idx_ff, s2_idx_in;
   logic [pncm_pkg::DistWidth-1:0]  best_dist_ff, best_dist_in;
   logic [IDX_BITS-1:0]             best_idx_ff, best_idx_in;
   logic                            hit_ff, hit_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pncm_pkg::CompWidth-1:0]  rsp_best_ff, rsp_best_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [PALETTE_ENTRIES-1:0]      valid_ff, valid_in;
   pncm_pkg::rgb_type               blend_ff, blend_in;
   pncm_pkg::comp_type              alpha_ff, alpha_in;
   logic [pncm_pkg::LimitWidth-1:0] blend_lim_ff, blend_lim_in;

   // datapath
   logic                            start;
   logic [pncm_pkg::LimitWidth-1:0] start_lim;
   logic                            ram_we;
   logic [ENTRY_BITS-1:0]           ram_wdata;
   logic [IDX_BITS-1:0]             ram_raddr;
   logic [ENTRY_BITS-1:0]           ram_rdata;
   pncm_pkg::rgb_type               ram_rgb;
   pncm_pkg::rgb_type               diff;
   pncm_pkg::rgb_type               mul_a;
   pncm_pkg::rgb_type               mul_b;
   pncm_pkg::prod3_type             mul_prod;
   logic [pncm_pkg::DistWidth-1:0]  sq_sum;

   assign req_index = req_tdata[7:0];
   assign req_rgb   = {req_tdata[15:8] & COMP_MASK,
                       req_tdata[23:16] & COMP_MASK,
                       req_tdata[31:24] & COMP_MASK};
   assign req_limit = req_tdata[40:32];
   assign req_op    = pncm_pkg::opcode_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_idx_ok = (pncm_pkg::LimitWidth'(req_index) < ENTRIES_LIM);

   // palette write straight from an accepted write request
   assign ram_we    = req_fire && (req_op == pncm_pkg::OP_WRITE) && req_idx_ok;
   assign ram_wdata = {req_rgb[2][COMPONENT_BITS-1:0],
                       req_rgb[1][COMPONENT_BITS-1:0],
                       req_rgb[0][COMPONENT_BITS-1:0]};
   assign ram_raddr = (state_ff == ST_SEARCH) ? addr_ff : idx_ff;

   pncm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (req_index[IDX_BITS-1:0]),
      .wr_data    (ram_wdata),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   // read data of an unwritten entry counts as black
   always_comb begin
      for (int l = 0; l < pncm_pkg::Lanes; l++) begin
         ram_rgb[l] = s1_ok_ff ?
            pncm_pkg::CompWidth'(ram_rdata[l*COMPONENT_BITS +: COMPONENT_BITS]) : '0;
         diff[l]    = pncm_pkg::abs_diff(tgt_ff[l], ram_rgb[l]);
      end
   end

   // shared multiplier: blend terms first, then squared differences during the scan
   always_comb begin
      case (state_ff)
         ST_BLEND_MUL: begin
            mul_a = blend_ff & {pncm_pkg::Lanes{COMP_MASK}};
            mul_b = {pncm_pkg::Lanes{alpha_ff}};
         end
         ST_BLEND_MIX: begin
            mul_a = tgt_ff;
            mul_b = {pncm_pkg::Lanes{pncm_pkg::comp_type'(pncm_pkg::AlphaFull - alpha_ff)}};
         end
         default: begin
            mul_a = diff;
            mul_b = diff;
         end
      endcase
   end

   pncm_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_prod)
   );

   assign sq_sum = pncm_pkg::DistWidth'(mul_prod[0]) + pncm_pkg::DistWidth'(mul_prod[1])
                 + pncm_pkg::DistWidth'(mul_prod[2]);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      last_in      = last_ff;
      tgt_in       = tgt_ff;
      quot_in      = quot_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      s1_vld_in    = 1'b0;
      s1_ok_in     = 1'b0;
      s1_idx_in    = addr_ff;
      s2_vld_in    = s1_vld_ff;
      s2_idx_in    = s1_idx_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_best_in  = rsp_best_ff;
      rsp_found_in = rsp_found_ff;
      valid_in     = valid_ff;
      blend_in     = blend_ff;
      alpha_in     = alpha_ff;
      blend_lim_in = blend_lim_ff;
      start        = 1'b0;
      start_lim    = '0;

      if (csr_we) begin
         case (csr_addr)
            pncm_pkg::CSR_BLEND_RED:   blend_in[2]  = csr_wdata[pncm_pkg::CompWidth-1:0];
            pncm_pkg::CSR_BLEND_GREEN: blend_in[1]  = csr_wdata[pncm_pkg::CompWidth-1:0];
            pncm_pkg::CSR_BLEND_BLUE:  blend_in[0]  = csr_wdata[pncm_pkg::CompWidth-1:0];
            pncm_pkg::CSR_BLEND_ALPHA: alpha_in     = csr_wdata[pncm_pkg::CompWidth-1:0];
            pncm_pkg::CSR_BLEND_LIMIT: blend_lim_in = csr_wdata;
            default: ;
         endcase
      end

      // compare stage: strict less keeps the lower index on ties
      if (s2_vld_ff && (sq_sum < best_dist_ff)) begin
         best_dist_in = sq_sum;
         best_idx_in  = s2_idx_ff;
         hit_in       = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  pncm_pkg::OP_WRITE: begin
                     if (req_idx_ok) begin
                        valid_in[req_index[IDX_BITS-1:0]] = 1'b1;
                     end
                  end
                  pncm_pkg::OP_FIND: begin
                     tgt_in    = req_rgb;
                     start     = 1'b1;
                     start_lim = pncm_pkg::clamp_limit(req_limit, ENTRIES_LIM);
                  end
                  pncm_pkg::OP_BLEND: begin
                     idx_in    = req_index[IDX_BITS-1:0];
                     idx_ok_in = req_idx_ok;
                     state_in  = ST_BLEND_READ;
                  end
                  default: ;   // drop the unused opcode
               endcase
            end
         end
         ST_BLEND_READ: begin
            s1_ok_in = idx_ok_ff && valid_ff[idx_ff];
            state_in = ST_BLEND_MUL;
         end
         ST_BLEND_MUL: begin
            tgt_in   = ram_rgb;   // hold the entry for the second term
            state_in = ST_BLEND_MIX;
         end
         ST_BLEND_MIX: begin
            for (int l = 0; l < pncm_pkg::Lanes; l++) begin
               quot_in[l] = pncm_pkg::div255(mul_prod[l]);
            end
            state_in = ST_BLEND_SUM;
         end
         ST_BLEND_SUM: begin
            for (int l = 0; l < pncm_pkg::Lanes; l++) begin
               tgt_in[l] = quot_ff[l] + pncm_pkg::div255(mul_prod[l]);
            end
            start     = 1'b1;
            start_lim = pncm_pkg::clamp_limit(blend_lim_ff, ENTRIES_LIM);
         end
         ST_SEARCH: begin
            s1_vld_in = 1'b1;
            s1_ok_in  = valid_ff[addr_ff];
            if (pncm_pkg::LimitWidth'(addr_ff) == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + IDX_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = pncm_pkg::CompWidth'(best_idx_ff);
               rsp_found_in = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (start) begin
         addr_in      = '0;
         last_in      = start_lim - pncm_pkg::LimitWidth'(1);
         best_dist_in = '1;
         best_idx_in  = '0;
         hit_in       = 1'b0;
         state_in     = (start_lim == '0) ? ST_FINISH : ST_SEARCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         best_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         blend_ff     <= '0;
         alpha_ff     <= '0;
         blend_lim_ff <= pncm_pkg::LimitWidth'(224);
         last_ff      <= '0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         hit_ff       <= hit_in;
         best_idx_ff  <= best_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         blend_ff     <= blend_in;
         alpha_ff     <= alpha_in;
         blend_lim_ff <= blend_lim_in;
         last_ff      <= last_in;
         addr_ff      <= addr_in;
      end
      tgt_ff       <= tgt_in;
      quot_ff      <= quot_in;
      idx_ff       <= idx_in;
      idx_ok_ff    <= idx_ok_in;
      s1_ok_ff     <= s1_ok_in;
      s1_idx_ff    <= s1_idx_in;
      s2_idx_ff    <= s2_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pncm_pkg::RspDataWidth - pncm_pkg::CompWidth - 1){1'b0}},
                        rsp_found_ff, rsp_best_ff};

   `PNCM_ASSERT_NOW(a_scan_in_limit, state_ff == ST_SEARCH,
      pncm_pkg::LimitWidth'(addr_ff) <= last_ff, "scan address past search limit")
   `PNCM_ASSERT_NOW(a_pipe_in_scan, s2_vld_ff,
      state_ff == ST_SEARCH || state_ff == ST_DRAIN, "compare stage active outside a scan")
   `PNCM_ASSERT_NOW(a_miss_is_zero, rsp_valid_ff && !rsp_found_ff,
      rsp_best_ff == '0, "response without a match carries a nonzero index")
   `PNCM_ASSERT_NEXT(a_finish_loads, state_ff == ST_FINISH && !rsp_valid_ff,
      rsp_valid_ff && state_ff == ST_IDLE, "finished search not loaded into output")

endmodule
